@@ hw/rtl/vertex_inner_angle_assert.svh @@
// ----------------------------------------------------------------------------
// vertex_inner_angle assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef VERTEX_INNER_ANGLE_ASSERT_SVH
`define VERTEX_INNER_ANGLE_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define VIA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define VIA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define VIA_ASSERT(lbl, clk, rst_n, prop, msg)
`define VIA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hw/rtl/via_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// via_pkg
// Fixed constants and the arctangent table of the vertex angle pipeline.
// ----------------------------------------------------------------------------
package via_pkg;

    // CORDIC depth and prescale of the vector components
    localparam int NUM_STAGES = 23;
    localparam int PRESCALE   = 24;

    // Angle accumulator: degrees * 65536, signed
    localparam int Z_W = 25;
    localparam int ANGLE_W = 16;

    localparam logic [Z_W-1:0]     DEG90_Q16    = 25'd5898240;
    localparam logic [Z_W-1:0]     DEG180_Q16   = 25'd11796480;
    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q8 = 16'd46080;
    localparam logic [Z_W-1:0]     ROUND_HALF   = 25'd128;

    // One result word
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               degenerate;
    } via_result_t;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic [Z_W-1:0] atan_q16(input int idx);
        logic [Z_W-1:0] v;
        case (idx)
            0:       v = 25'd2949120;
            1:       v = 25'd1740967;
            2:       v = 25'd919879;
            3:       v = 25'd466945;
            4:       v = 25'd234379;
            5:       v = 25'd117304;
            6:       v = 25'd58666;
            7:       v = 25'd29335;
            8:       v = 25'd14668;
            9:       v = 25'd7334;
            10:      v = 25'd3667;
            11:      v = 25'd1833;
            12:      v = 25'd917;
            13:      v = 25'd458;
            14:      v = 25'd229;
            15:      v = 25'd115;
            16:      v = 25'd57;
            17:      v = 25'd29;
            18:      v = 25'd14;
            19:      v = 25'd7;
            20:      v = 25'd4;
            21:      v = 25'd2;
            22:      v = 25'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/vertex_inner_angle.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_inner_angle
// Angle at the far point of a three-point vertex, by a pipelined CORDIC.
// ----------------------------------------------------------------------------
//  channel | dir | word contents
//  --------+-----+-----------------------------------------------------------
//  s_axis  | in  | first_x, first_y, second_x, second_y, center_x, center_y
//  m_axis  | out | angle_deg_q8 in tdata, degenerate in tuser
//
//  One word enters per cycle while the skid entry is empty. A word passes
//  through six setup stages (distances, selection, products, cross/dot),
//  one prescale stage, 23 CORDIC vectoring stages and the output register.
//  A two-entry output buffer (output register plus skid) decouples m_tready;
//  the whole pipeline holds while the skid entry is full.
//  rst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
`include "vertex_inner_angle_assert.svh"

module vertex_inner_angle
    import via_pkg::*;
#(
    parameter int COORD_WIDTH = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // first_x, first_y, second_x, second_y, center_x, center_y; zero padded
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // angle_deg_q8
    output logic [ANGLE_W-1:0]     m_tdata,
    // degenerate
    output logic                   m_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready
);

    localparam int W   = COORD_WIDTH;
    localparam int DW  = W + 1;        // coordinate difference
    localparam int SQW = 2 * W + 1;    // one squared difference
    localparam int DSW = 2 * W + 2;    // squared distance
    localparam int MW  = 2 * W + 2;    // one product of differences
    localparam int PW  = 2 * W + 3;    // cross and dot
    localparam int CW  = 2 * W + 29;   // CORDIC x and y

    logic skid_valid_reg;
    logic en;
    logic accept;

    // Advance every stage unless the skid entry holds a result
    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // ------------------------------------------------------------------
    // Stage 1: unpack and take differences to the center
    // ------------------------------------------------------------------
    logic         v1_reg;
    logic [W-1:0] x1_1_reg, y1_1_reg, x2_1_reg, y2_1_reg, cx_1_reg, cy_1_reg;
    logic signed [DW-1:0] d1x_reg, d1y_reg, d2x_reg, d2y_reg;

    logic [W-1:0] in_x1, in_y1, in_x2, in_y2, in_cx, in_cy;
    assign in_x1 = s_tdata[0*W +: W];
    assign in_y1 = s_tdata[1*W +: W];
    assign in_x2 = s_tdata[2*W +: W];
    assign in_y2 = s_tdata[3*W +: W];
    assign in_cx = s_tdata[4*W +: W];
    assign in_cy = s_tdata[5*W +: W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_1_reg <= in_x1;
            y1_1_reg <= in_y1;
            x2_1_reg <= in_x2;
            y2_1_reg <= in_y2;
            cx_1_reg <= in_cx;
            cy_1_reg <= in_cy;
            d1x_reg  <= $signed({1'b0, in_x1}) - $signed({1'b0, in_cx});
            d1y_reg  <= $signed({1'b0, in_y1}) - $signed({1'b0, in_cy});
            d2x_reg  <= $signed({1'b0, in_x2}) - $signed({1'b0, in_cx});
            d2y_reg  <= $signed({1'b0, in_y2}) - $signed({1'b0, in_cy});
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: square the differences
    // ------------------------------------------------------------------
    logic           v2_reg;
    logic [W-1:0]   x1_2_reg, y1_2_reg, x2_2_reg, y2_2_reg, cx_2_reg, cy_2_reg;
    logic [SQW-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg;

    logic signed [MW-1:0] sq1x, sq1y, sq2x, sq2y;
    assign sq1x = d1x_reg * d1x_reg;
    assign sq1y = d1y_reg * d1y_reg;
    assign sq2x = d2x_reg * d2x_reg;
    assign sq2y = d2y_reg * d2y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_2_reg <= x1_1_reg;
            y1_2_reg <= y1_1_reg;
            x2_2_reg <= x2_1_reg;
            y2_2_reg <= y2_1_reg;
            cx_2_reg <= cx_1_reg;
            cy_2_reg <= cy_1_reg;
            s1x_reg  <= sq1x[SQW-1:0];
            s1y_reg  <= sq1y[SQW-1:0];
            s2x_reg  <= sq2x[SQW-1:0];
            s2y_reg  <= sq2y[SQW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: compare squared distances; a tie makes the second point B
    // ------------------------------------------------------------------
    logic         v3_reg;
    logic [W-1:0] x1_3_reg, y1_3_reg, x2_3_reg, y2_3_reg, cx_3_reg, cy_3_reg;
    logic         first_near_reg;

    logic [DSW-1:0] dist1, dist2;
    assign dist1 = {1'b0, s1x_reg} + {1'b0, s1y_reg};
    assign dist2 = {1'b0, s2x_reg} + {1'b0, s2y_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_3_reg       <= x1_2_reg;
            y1_3_reg       <= y1_2_reg;
            x2_3_reg       <= x2_2_reg;
            y2_3_reg       <= y2_2_reg;
            cx_3_reg       <= cx_2_reg;
            cy_3_reg       <= cy_2_reg;
            first_near_reg <= (dist1 < dist2);
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: pick A and B, form P = B - A and Q = C - A
    // ------------------------------------------------------------------
    logic                 v4_reg;
    logic                 deg4_reg;
    logic signed [DW-1:0] px_reg, py_reg, qx_reg, qy_reg;

    logic [W-1:0] ax, ay, bx, by;
    always_comb
    begin
        if (first_near_reg)
        begin
            bx = x1_3_reg;
            by = y1_3_reg;
            ax = x2_3_reg;
            ay = y2_3_reg;
        end
        else
        begin
            bx = x2_3_reg;
            by = y2_3_reg;
            ax = x1_3_reg;
            ay = y1_3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg4_reg <= ((ax == bx) && (ay == by)) || ((ax == cx_3_reg) && (ay == cy_3_reg));
            px_reg   <= $signed({1'b0, bx}) - $signed({1'b0, ax});
            py_reg   <= $signed({1'b0, by}) - $signed({1'b0, ay});
            qx_reg   <= $signed({1'b0, cx_3_reg}) - $signed({1'b0, ax});
            qy_reg   <= $signed({1'b0, cy_3_reg}) - $signed({1'b0, ay});
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: the four products of cross and dot
    // ------------------------------------------------------------------
    logic                 v5_reg;
    logic                 deg5_reg;
    logic signed [MW-1:0] pxqy_reg, pyqx_reg, pxqx_reg, pyqy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg5_reg <= deg4_reg;
            pxqy_reg <= px_reg * qy_reg;
            pyqx_reg <= py_reg * qx_reg;
            pxqx_reg <= px_reg * qx_reg;
            pyqy_reg <= py_reg * qy_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: cross and dot
    // ------------------------------------------------------------------
    logic                 v6_reg;
    logic                 deg6_reg;
    logic signed [PW-1:0] cross_reg, dot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg6_reg  <= deg5_reg;
            cross_reg <= PW'(pxqy_reg) - PW'(pyqx_reg);
            dot_reg   <= PW'(pxqx_reg) + PW'(pyqy_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: fold into the right half plane and prescale
    // ------------------------------------------------------------------
    logic signed [CW-1:0]  xc_reg [0:NUM_STAGES];
    logic signed [CW-1:0]  yc_reg [0:NUM_STAGES];
    logic signed [Z_W-1:0] zc_reg [0:NUM_STAGES];
    logic                  vc_reg [0:NUM_STAGES];
    logic                  degc_reg [0:NUM_STAGES];

    logic signed [PW-1:0]  cross_abs;
    logic signed [PW-1:0]  x_fold, y_fold;
    logic signed [Z_W-1:0] z_fold;

    always_comb
    begin
        cross_abs = cross_reg[PW-1] ? -cross_reg : cross_reg;
        if (dot_reg[PW-1])
        begin
            x_fold = cross_abs;
            y_fold = -dot_reg;
            z_fold = DEG90_Q16;
        end
        else
        begin
            x_fold = dot_reg;
            y_fold = cross_abs;
            z_fold = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vc_reg[0] <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            degc_reg[0] <= deg6_reg;
            xc_reg[0]   <= CW'(x_fold) <<< PRESCALE;
            yc_reg[0]   <= CW'(y_fold) <<< PRESCALE;
            zc_reg[0]   <= z_fold;
        end
    end

    // ------------------------------------------------------------------
    // CORDIC vectoring stages: rotate y toward zero, sum angles in z
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NUM_STAGES; k++)
    begin : g_cordic
        logic signed [CW-1:0] xs, ys;
        assign xs = xc_reg[k] >>> k;
        assign ys = yc_reg[k] >>> k;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vc_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vc_reg[k+1] <= vc_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                degc_reg[k+1] <= degc_reg[k];
                if (!yc_reg[k][CW-1])
                begin
                    xc_reg[k+1] <= xc_reg[k] + ys;
                    yc_reg[k+1] <= yc_reg[k] - xs;
                    zc_reg[k+1] <= zc_reg[k] + $signed(atan_q16(k));
                end
                else
                begin
                    xc_reg[k+1] <= xc_reg[k] - ys;
                    yc_reg[k+1] <= yc_reg[k] + xs;
                    zc_reg[k+1] <= zc_reg[k] - $signed(atan_q16(k));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Clamp to 0..180 degrees and round to 8 fraction bits
    // ------------------------------------------------------------------
    logic signed [Z_W-1:0] z_last;
    logic [Z_W-1:0]        z_clamp;
    logic [Z_W-1:0]        z_round;
    logic [ANGLE_W-1:0]    angle_q8;
    via_result_t           fin;
    logic                  fin_valid;

    assign z_last = zc_reg[NUM_STAGES];

    always_comb
    begin
        if (z_last[Z_W-1])
        begin
            z_clamp = '0;
        end
        else if ($unsigned(z_last) > DEG180_Q16)
        begin
            z_clamp = DEG180_Q16;
        end
        else
        begin
            z_clamp = $unsigned(z_last);
        end
        z_round  = (z_clamp + ROUND_HALF) >> 8;
        angle_q8 = (z_round[ANGLE_W-1:0] > ANGLE_MAX_Q8) ? ANGLE_MAX_Q8
                                                          : z_round[ANGLE_W-1:0];
        fin.degenerate = degc_reg[NUM_STAGES];
        fin.angle      = degc_reg[NUM_STAGES] ? '0 : angle_q8;
    end

    assign fin_valid = vc_reg[NUM_STAGES] && en;

    // ------------------------------------------------------------------
    // Output register with one skid entry
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    via_result_t out_reg;
    via_result_t skid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            // Drain the skid entry first, else take the pipeline word
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= fin_valid;
            end
        end
        else if (fin_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            out_reg <= skid_valid_reg ? skid_reg : fin;
        end
        else if (fin_valid)
        begin
            skid_reg <= fin;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.angle;
    assign m_tuser  = out_reg.degenerate;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `VIA_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid full with empty output register")
    `VIA_ASSERT_IMPL(a_skid_fill_on_stall, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg && !m_tready), "skid filled without an output stall")
    `VIA_ASSERT_IMPL(a_degenerate_zero, clk, rst_n, out_valid_reg && out_reg.degenerate, out_reg.angle == '0, "degenerate result with nonzero angle")
    `VIA_ASSERT_IMPL(a_angle_range, clk, rst_n, out_valid_reg, out_reg.angle <= ANGLE_MAX_Q8, "angle above 180 degrees")
    `VIA_ASSERT(a_hold_when_full, clk, rst_n, skid_valid_reg |=> (skid_valid_reg || out_valid_reg), "result lost while draining skid")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for vertex_inner_angle. Point triples go into the input
// stream in bursts with random gaps, and a predictor computes the expected
// angle word for each one. The output side stalls on a rotating pattern, and
// once it holds off long enough to back the pipeline up into its input. Each
// word taken from the output is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
    import via_pkg::*;
();

    localparam int COORD_W     = 10;
    localparam int TDATA_W     = ((6*COORD_W+7)/8)*8;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    localparam int HOLDOFF_LEN = 400;
    localparam int DRAIN_WAIT  = 40;
    localparam int TIMEOUT_NS  = 2000000;

    // atan(2^-i) in degrees * 65536, nearest
    localparam logic [0:NUM_STAGES-1][22:0] ATAN_STEP_Q16 = '{
        23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
        23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
        23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
        23'd1
    };

    // One input word, first_x in the lowest bits
    typedef struct packed {
        logic [COORD_W-1:0] center_y;
        logic [COORD_W-1:0] center_x;
        logic [COORD_W-1:0] second_y;
        logic [COORD_W-1:0] second_x;
        logic [COORD_W-1:0] first_y;
        logic [COORD_W-1:0] first_x;
    } vertex_points_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    // first_x, first_y, second_x, second_y, center_x, center_y; zero padded
    logic [TDATA_W-1:0] s_tdata = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    // angle_deg_q8
    logic [ANGLE_W-1:0] m_tdata;
    // degenerate
    logic               m_tuser;
    logic               m_tvalid;
    logic               m_tready = 1'b0;

    via_result_t angle_expect_q[$];
    int unsigned fail_count = 0;
    int          burst_left = 0;
    int          sender_max_gap = 4;
    int unsigned holdoff_req = 0;
    int unsigned holdoff_seen = 0;
    int          holdoff_left = 0;
    logic [15:0] rx_cycle = '0;

    vertex_inner_angle #(
        .COORD_WIDTH(COORD_W)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Angle at the far candidate, by the same vectoring CORDIC as the block
    function automatic via_result_t predict_inner_angle(input vertex_points_t p);
        longint fx, fy, sx, sy, cx, cy, dist_first, dist_second;
        longint ax, ay, bx, by, px, py, qx, qy, cross_abs, dot, x, y, z, xs, ys, t;
        int i;
        via_result_t r;
        fx = longint'(p.first_x);
        fy = longint'(p.first_y);
        sx = longint'(p.second_x);
        sy = longint'(p.second_y);
        cx = longint'(p.center_x);
        cy = longint'(p.center_y);
        dist_first = (fx - cx) * (fx - cx) + (fy - cy) * (fy - cy);
        dist_second = (sx - cx) * (sx - cx) + (sy - cy) * (sy - cy);
        // Nearer candidate is B; a tie goes to the second one
        if (dist_first < dist_second)
        begin
            bx = fx; by = fy; ax = sx; ay = sy;
        end
        else
        begin
            bx = sx; by = sy; ax = fx; ay = fy;
        end
        qx = cx - ax;
        qy = cy - ay;
        px = bx - ax;
        py = by - ay;
        r.angle = '0;
        r.degenerate = 1'b1;
        if ((px == 0 && py == 0) || (qx == 0 && qy == 0))
            return r;
        cross_abs = px * qy - py * qx;
        if (cross_abs < 0)
            cross_abs = -cross_abs;
        dot = px * qx + py * qy;
        x = dot;
        y = cross_abs;
        z = 0;
        // Rotate a left half-plane vector by 90 degrees first
        if (x < 0)
        begin
            t = x;
            x = y;
            y = -t;
            z = longint'(DEG90_Q16);
        end
        x = x <<< PRESCALE;
        y = y <<< PRESCALE;
        for (i = 0; i < NUM_STAGES; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + longint'(ATAN_STEP_Q16[i]);
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - longint'(ATAN_STEP_Q16[i]);
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(DEG180_Q16))
            z = longint'(DEG180_Q16);
        z = (z + longint'(ROUND_HALF)) >>> 8;
        if (z > longint'(ANGLE_MAX_Q8))
            z = longint'(ANGLE_MAX_Q8);
        r.angle = z[ANGLE_W-1:0];
        r.degenerate = 1'b0;
        return r;
    endfunction

    function automatic vertex_points_t make_points(input int fx, input int fy, input int sx,
                                                   input int sy, input int cx, input int cy);
        vertex_points_t p;
        p.first_x  = fx[COORD_W-1:0];
        p.first_y  = fy[COORD_W-1:0];
        p.second_x = sx[COORD_W-1:0];
        p.second_y = sy[COORD_W-1:0];
        p.center_x = cx[COORD_W-1:0];
        p.center_y = cy[COORD_W-1:0];
        return p;
    endfunction

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    function automatic int pick_edge_coord();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return COORD_MAX / 2;
            3: return COORD_MAX / 2 + 1;
            4: return COORD_MAX - 1;
            5: return COORD_MAX;
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    // Random triple, weighted toward shapes that reach the special cases
    function automatic vertex_points_t random_points();
        int kind, cx, cy, dx, dy, spread, ka, kb, fx, fy;
        kind = $urandom_range(0, 99);
        cx = $urandom_range(0, COORD_MAX);
        cy = $urandom_range(0, COORD_MAX);
        if (kind < 40)
            return make_points($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                               $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                               cx, cy);
        if (kind < 65)
        begin
            // tight cluster around the center
            case ($urandom_range(0, 3))
                0: spread = 1;
                1: spread = 3;
                2: spread = 15;
                default: spread = 100;
            endcase
            return make_points(clip_coord(cx + $urandom_range(0, 2*spread) - spread),
                               clip_coord(cy + $urandom_range(0, 2*spread) - spread),
                               clip_coord(cx + $urandom_range(0, 2*spread) - spread),
                               clip_coord(cy + $urandom_range(0, 2*spread) - spread),
                               cx, cy);
        end
        if (kind < 75)
            return make_points(pick_edge_coord(), pick_edge_coord(), pick_edge_coord(),
                               pick_edge_coord(), pick_edge_coord(), pick_edge_coord());
        if (kind < 85)
        begin
            // identical candidates, center sometimes on top of them
            fx = $urandom_range(0, COORD_MAX);
            fy = $urandom_range(0, COORD_MAX);
            if ($urandom_range(0, 3) == 0)
                return make_points(fx, fy, fx, fy, fx, fy);
            return make_points(fx, fy, fx, fy, cx, cy);
        end
        if (kind < 95)
        begin
            // equal distances: swap the offset's components, or negate its x offset
            cx = $urandom_range(200, COORD_MAX - 200);
            cy = $urandom_range(200, COORD_MAX - 200);
            dx = $urandom_range(0, 400) - 200;
            dy = $urandom_range(0, 400) - 200;
            if ($urandom_range(0, 1) == 0)
                return make_points(cx + dx, cy + dy, cx + dy, cy + dx, cx, cy);
            return make_points(cx + dx, cy + dy, cx - dx, cy + dy, cx, cy);
        end
        // collinear points on one ray from the center
        cx = $urandom_range(480, 540);
        cy = $urandom_range(480, 540);
        dx = $urandom_range(0, 16) - 8;
        dy = $urandom_range(0, 16) - 8;
        ka = $urandom_range(0, 60);
        kb = $urandom_range(0, 60);
        return make_points(cx + ka*dx, cy + ka*dy, cx + kb*dx, cy + kb*dy, cx, cy);
    endfunction

    // Offer one word, burst by burst; record its prediction once it is taken
    task automatic send_points(input vertex_points_t p);
        int gap;
        if (burst_left == 0)
        begin
            gap = (sender_max_gap == 0) ? 0 : $urandom_range(0, sender_max_gap);
            burst_left = $urandom_range(1, 32);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tdata  <= {{(TDATA_W-6*COORD_W){1'b0}}, p};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        angle_expect_q = {angle_expect_q, predict_inner_angle(p)};
        burst_left--;
    endtask

    task automatic test_directed_vertices();
        sender_max_gap = 3;
        send_points(make_points(0, 0, 0, 0, 0, 0));
        send_points(make_points(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                COORD_MAX, COORD_MAX));
        // B on the center: both vectors coincide
        send_points(make_points(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        // identical candidates away from the center
        send_points(make_points(5, 5, 5, 5, 100, 7));
        send_points(make_points(COORD_MAX, 0, COORD_MAX, 0, 0, COORD_MAX));
        // distance tie, both orientations
        send_points(make_points(110, 100, 100, 110, 100, 100));
        send_points(make_points(100, 110, 110, 100, 100, 100));
        send_points(make_points(COORD_MAX, 0, 0, COORD_MAX, 0, 0));
        // first candidate nearer
        send_points(make_points(0, 0, 0, COORD_MAX, COORD_MAX, 0));
        send_points(make_points(101, 100, 200, 180, 100, 100));
        // collinear on one side of the center
        send_points(make_points(10, 0, 20, 0, 0, 0));
        send_points(make_points(COORD_MAX, COORD_MAX, 512, 512, 0, 0));
        // smallest nonzero angles at full reach
        send_points(make_points(0, 0, COORD_MAX, 1, COORD_MAX, 0));
        send_points(make_points(0, COORD_MAX, 1, 0, 0, 0));
        // alternating bit patterns
        send_points(make_points('h2AA, 'h155, 'h155, 'h2AA, 'h2AA, 'h2AA));
        send_points(make_points('h155, 'h2AA, 'h2AA, 'h155, 'h155, 'h155));
        // one-pixel triangle, then a full-width one
        send_points(make_points(512, 512, 513, 512, 512, 513));
        send_points(make_points(0, COORD_MAX, COORD_MAX, 0, 1, 1));
    endtask

    task automatic test_random_vertices(input int count);
        int n;
        for (n = 0; n < count; n++)
        begin
            // change the sender's gap size now and then
            if (n % 200 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: sender_max_gap = 0;
                    1: sender_max_gap = 2;
                    default: sender_max_gap = 8;
                endcase
            end
            send_points(random_points());
        end
    endtask

    // Hold the output off long enough that the input stalls behind it
    task automatic test_output_holdoff(input int count);
        int n;
        sender_max_gap = 0;
        holdoff_req <= holdoff_req + 1;
        for (n = 0; n < count; n++)
            send_points(random_points());
        sender_max_gap = 4;
    endtask

    // Output-side ready: rotating stall pattern plus requested hold-offs
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1'b1;
        if (holdoff_req != holdoff_seen)
        begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_LEN;
            m_tready     <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            holdoff_left <= holdoff_left - 1;
            m_tready     <= 1'b0;
        end
        else
        begin
            case (rx_cycle[10:9])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= 1'($urandom_range(0, 1));
                2'd2: m_tready <= ($urandom_range(0, 5) != 0);
                default: m_tready <= (rx_cycle[2:0] == 3'd0);
            endcase
        end
    end

    // Compare each taken output word with the oldest prediction
    always @(posedge clk)
    begin : result_check
        via_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (angle_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word angle=%0d degenerate=%0b",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end
            else
            begin
                want = angle_expect_q.pop_front();
                if (m_tdata !== want.angle)
                begin
                    $display("%0t: angle expected %0d actual %0d",
                             $time, want.angle, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want.degenerate)
                begin
                    $display("%0t: degenerate expected %0b actual %0b",
                             $time, want.degenerate, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_vertices();
        test_random_vertices(800);
        test_output_holdoff(150);
        test_random_vertices(850);
        s_tvalid <= 1'b0;
        // drain what is still in flight
        while (angle_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d words outstanding", $time, angle_expect_q.size());
        $display("testbench NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/via_pkg.sv
hw/rtl/vertex_inner_angle.sv
tb/testbench.sv
